[src/ovwb_pkg.sv]
// ----------------------------------------------------------------------------
// Overrun window bypass monitor package
// Shared constants: window sizing, register map, opcodes and route codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ovwb_pkg;

    // Ring depth and derived index widths
    localparam int MAX_WINDOW = 64;
    localparam int POS_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int LEN_W      = $clog2(MAX_WINDOW + 1) + 1;

    // Field widths fixed by the register and item layout
    localparam int DATA_W     = 32;
    localparam int WLEN_W     = 7;
    localparam int WOVER_W    = 7;
    localparam int ROUTE_W    = 2;
    localparam int APB_AW     = 5;

    localparam logic [WOVER_W-1:0] WINDOW_OVER_MAX = 7'd127;
    localparam logic [DATA_W-1:0]  RECOVER_MANUAL  = 32'hFFFF_FFFF;

    // Register indexes (byte address is 4 * index)
    localparam logic [2:0] REG_BUDGET_LIMIT   = 3'd0;
    localparam logic [2:0] REG_HARD_CEILING   = 3'd1;
    localparam logic [2:0] REG_WINDOW_LENGTH  = 3'd2;
    localparam logic [2:0] REG_TRIP_THRESHOLD = 3'd3;
    localparam logic [2:0] REG_RECOVER_AFTER  = 3'd4;
    localparam logic [2:0] REG_MANUAL_BYPASS  = 3'd5;

    // Opcodes
    localparam logic OP_CALL  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Route codes
    localparam logic [ROUTE_W-1:0] ROUTE_PROCESSED = 2'd0;
    localparam logic [ROUTE_W-1:0] ROUTE_BYPASS    = 2'd1;
    localparam logic [ROUTE_W-1:0] ROUTE_SILENT    = 2'd2;

endpackage

`default_nettype wire

[src/overrun_window_bypass_monitor.sv]
// ----------------------------------------------------------------------------
// Overrun window bypass monitor
// Tracks call durations in a sliding window and drives automatic bypass.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on i_in_valid/o_in_ready with i_opcode, i_duration_us and
//   i_faulted. Each request yields exactly one result on o_out_valid /
//   i_out_ready carrying the route, the bypass state and the statistics.
//   An accepted request waits in the input register, which feeds the result
//   register. Throughput: one request per cycle while results are taken; the
//   window ring is a 64-entry memory whose entry at the current position is
//   prefetched into a read register: one read and at most one write per call.
//   Recovery clears the window at once through per-entry valid bits.
//   Configuration sits on an APB-style port (six 32-bit registers at 4*i),
//   with pready tied high; write only while no request is outstanding.
//   Reset (synchronous, active low) restores register defaults, empties the
//   window and zeroes all statistics; no clearing pass is needed.
//   When the receiver stalls, the result holds and the input register still
//   takes one more request, after which o_in_ready drops until the result
//   is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module overrun_window_bypass_monitor (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // request channel
    input  wire logic                               i_in_valid,
    output logic                                    o_in_ready,
    input  wire logic                               i_opcode,
    input  wire logic [ovwb_pkg::DATA_W-1:0]        i_duration_us,
    input  wire logic                               i_faulted,
    // result channel
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output logic [ovwb_pkg::ROUTE_W-1:0]            o_route,
    output logic                                    o_bypass_engaged,
    output logic [ovwb_pkg::DATA_W-1:0]             o_call_count,
    output logic [ovwb_pkg::DATA_W-1:0]             o_over_count_total,
    output logic [ovwb_pkg::DATA_W-1:0]             o_bypassed_total,
    output logic [ovwb_pkg::DATA_W-1:0]             o_fault_total,
    output logic [ovwb_pkg::DATA_W-1:0]             o_trip_total,
    output logic [ovwb_pkg::DATA_W-1:0]             o_last_duration,
    output logic [ovwb_pkg::DATA_W-1:0]             o_peak_duration,
    // configuration port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [ovwb_pkg::APB_AW-1:0]        paddr,
    input  wire logic [ovwb_pkg::DATA_W-1:0]        pwdata,
    output logic [ovwb_pkg::DATA_W-1:0]             prdata,
    output logic                                    pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [ovwb_pkg::DATA_W-1:0]  r_budget_limit;
    logic [ovwb_pkg::DATA_W-1:0]  r_hard_ceiling;
    logic [ovwb_pkg::WLEN_W-1:0]  r_window_length;
    logic [ovwb_pkg::WOVER_W-1:0] r_trip_threshold;
    logic [ovwb_pkg::DATA_W-1:0]  r_recover_after;
    logic                         r_manual_bypass;

    logic       cfg_wr;
    logic [2:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget_limit   <= '0;
            r_hard_ceiling   <= '1;
            r_window_length  <= ovwb_pkg::WLEN_W'(1);
            r_trip_threshold <= ovwb_pkg::WOVER_W'(1);
            r_recover_after  <= '1;
            r_manual_bypass  <= 1'b0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                ovwb_pkg::REG_BUDGET_LIMIT:   r_budget_limit   <= pwdata;
                ovwb_pkg::REG_HARD_CEILING:   r_hard_ceiling   <= pwdata;
                ovwb_pkg::REG_WINDOW_LENGTH:  r_window_length  <= pwdata[ovwb_pkg::WLEN_W-1:0];
                ovwb_pkg::REG_TRIP_THRESHOLD: r_trip_threshold <= pwdata[ovwb_pkg::WOVER_W-1:0];
                ovwb_pkg::REG_RECOVER_AFTER:  r_recover_after  <= pwdata;
                ovwb_pkg::REG_MANUAL_BYPASS:  r_manual_bypass  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            ovwb_pkg::REG_BUDGET_LIMIT:   prdata = r_budget_limit;
            ovwb_pkg::REG_HARD_CEILING:   prdata = r_hard_ceiling;
            ovwb_pkg::REG_WINDOW_LENGTH:  prdata = ovwb_pkg::DATA_W'(r_window_length);
            ovwb_pkg::REG_TRIP_THRESHOLD: prdata = ovwb_pkg::DATA_W'(r_trip_threshold);
            ovwb_pkg::REG_RECOVER_AFTER:  prdata = r_recover_after;
            ovwb_pkg::REG_MANUAL_BYPASS:  prdata = ovwb_pkg::DATA_W'(r_manual_bypass);
            default:                      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input register and pipeline handshake
    // ------------------------------------------------------------------
    logic                        r_in_vld;
    logic                        r_in_opcode;
    logic [ovwb_pkg::DATA_W-1:0] r_in_dur;
    logic                        r_in_faulted;
    logic                        r_out_vld;
    logic                        fire;
    logic                        in_take;

    assign fire       = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || fire;
    assign in_take    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (fire) begin
                r_in_vld <= 1'b0;
            end
            if (fire) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_opcode  <= i_opcode;
            r_in_dur     <= i_duration_us;
            r_in_faulted <= i_faulted;
        end
    end

    // ------------------------------------------------------------------
    // Window and statistics state
    // ------------------------------------------------------------------
    logic [ovwb_pkg::DATA_W-1:0]     r_ring [ovwb_pkg::MAX_WINDOW];
    logic [ovwb_pkg::MAX_WINDOW-1:0] r_ring_vld;
    logic [ovwb_pkg::DATA_W-1:0]     r_rd_data;
    logic                            r_rd_ok;
    logic [ovwb_pkg::POS_W-1:0]      r_pos;
    logic [ovwb_pkg::WOVER_W-1:0]    r_window_over;
    logic [ovwb_pkg::DATA_W-1:0]     r_clean_run;
    logic                            r_auto_bypass;
    logic [ovwb_pkg::DATA_W-1:0]     r_calls;
    logic [ovwb_pkg::DATA_W-1:0]     r_overs;
    logic [ovwb_pkg::DATA_W-1:0]     r_bypasses;
    logic [ovwb_pkg::DATA_W-1:0]     r_faults;
    logic [ovwb_pkg::DATA_W-1:0]     r_trips;
    logic [ovwb_pkg::DATA_W-1:0]     r_latest;
    logic [ovwb_pkg::DATA_W-1:0]     r_largest;
    logic [ovwb_pkg::ROUTE_W-1:0]    r_route;
    logic                            r_bypass_engaged;

    logic [ovwb_pkg::POS_W-1:0]      n_pos;
    logic [ovwb_pkg::WOVER_W-1:0]    n_window_over;
    logic [ovwb_pkg::DATA_W-1:0]     n_clean_run;
    logic                            n_auto_bypass;
    logic [ovwb_pkg::DATA_W-1:0]     n_calls;
    logic [ovwb_pkg::DATA_W-1:0]     n_overs;
    logic [ovwb_pkg::DATA_W-1:0]     n_bypasses;
    logic [ovwb_pkg::DATA_W-1:0]     n_faults;
    logic [ovwb_pkg::DATA_W-1:0]     n_trips;
    logic [ovwb_pkg::DATA_W-1:0]     n_latest;
    logic [ovwb_pkg::DATA_W-1:0]     n_largest;
    logic [ovwb_pkg::ROUTE_W-1:0]    n_route;
    logic                            ring_we;
    logic                            ring_clr;

    // Datapath helpers
    logic [ovwb_pkg::DATA_W-1:0]  old_sample;
    logic [ovwb_pkg::LEN_W-1:0]   eff_len;
    logic [ovwb_pkg::LEN_W-1:0]   pos_inc;
    logic [ovwb_pkg::POS_W-1:0]   pos_wrap;
    logic                         old_over;
    logic                         new_over;
    logic [ovwb_pkg::WOVER_W-1:0] wo_dec;
    logic [ovwb_pkg::WOVER_W-1:0] wo_new;
    logic [ovwb_pkg::DATA_W-1:0]  clean_inc;
    logic                         recovered;

    // Entries never written since reset or recovery read as zero
    assign old_sample = r_rd_ok ? r_rd_data : '0;

    always_comb begin
        if (r_window_length == '0) begin
            eff_len = ovwb_pkg::LEN_W'(1);
        end else if (32'(r_window_length) > ovwb_pkg::MAX_WINDOW) begin
            eff_len = ovwb_pkg::LEN_W'(ovwb_pkg::MAX_WINDOW);
        end else begin
            eff_len = ovwb_pkg::LEN_W'(r_window_length);
        end
    end

    assign pos_inc  = ovwb_pkg::LEN_W'(r_pos) + ovwb_pkg::LEN_W'(1);
    assign pos_wrap = (pos_inc >= eff_len) ? '0 : ovwb_pkg::POS_W'(pos_inc);

    assign old_over = old_sample > r_budget_limit;
    assign new_over = r_in_dur > r_budget_limit;
    assign wo_dec   = (old_over && r_window_over != '0) ? r_window_over - 1'b1
                                                         : r_window_over;
    assign wo_new   = (new_over && wo_dec < ovwb_pkg::WINDOW_OVER_MAX) ? wo_dec + 1'b1
                                                                       : wo_dec;

    assign clean_inc = r_clean_run + 1'b1;
    assign recovered = clean_inc >= r_recover_after;

    always_comb begin
        n_pos         = r_pos;
        n_window_over = r_window_over;
        n_clean_run   = r_clean_run;
        n_auto_bypass = r_auto_bypass;
        n_calls       = r_calls;
        n_overs       = r_overs;
        n_bypasses    = r_bypasses;
        n_faults      = r_faults;
        n_trips       = r_trips;
        n_latest      = r_latest;
        n_largest     = r_largest;
        n_route       = r_route;
        ring_we       = 1'b0;
        ring_clr      = 1'b0;

        if (fire) begin
            if (r_in_opcode == ovwb_pkg::OP_CLEAR) begin
                n_calls    = '0;
                n_overs    = '0;
                n_bypasses = '0;
                n_faults   = '0;
                n_trips    = '0;
                n_latest   = '0;
                n_largest  = '0;
                n_route    = ovwb_pkg::ROUTE_SILENT;
            end else begin
                n_calls = r_calls + 1'b1;
                if (r_manual_bypass || r_auto_bypass) begin
                    n_bypasses = r_bypasses + 1'b1;
                    n_route    = ovwb_pkg::ROUTE_BYPASS;
                    // Clean run only advances under automatic bypass alone, and not when recovery is manual
                    if (!r_manual_bypass && r_recover_after != ovwb_pkg::RECOVER_MANUAL) begin
                        if (recovered) begin
                            ring_clr      = 1'b1;
                            n_pos         = '0;
                            n_window_over = '0;
                            n_clean_run   = '0;
                            n_auto_bypass = 1'b0;
                        end else begin
                            n_clean_run = clean_inc;
                        end
                    end
                end else if (r_in_faulted) begin
                    n_faults      = r_faults + 1'b1;
                    n_auto_bypass = 1'b1;
                    n_trips       = r_trips + 1'b1;
                    n_clean_run   = '0;
                    n_route       = ovwb_pkg::ROUTE_SILENT;
                end else begin
                    n_latest = r_in_dur;
                    if (r_in_dur > r_largest) begin
                        n_largest = r_in_dur;
                    end
                    n_route = ovwb_pkg::ROUTE_PROCESSED;
                    if (r_in_dur >= r_hard_ceiling) begin
                        n_overs       = r_overs + 1'b1;
                        n_auto_bypass = 1'b1;
                        n_trips       = r_trips + 1'b1;
                        n_clean_run   = '0;
                    end else begin
                        ring_we       = 1'b1;
                        n_window_over = wo_new;
                        n_pos         = pos_wrap;
                        if (new_over) begin
                            n_overs = r_overs + 1'b1;
                        end
                        if (wo_new >= r_trip_threshold) begin
                            n_auto_bypass = 1'b1;
                            n_trips       = r_trips + 1'b1;
                            n_clean_run   = '0;
                        end
                    end
                end
            end
        end
    end

    // Ring storage; read register always holds the entry at the next position
    always_ff @(posedge i_clk) begin
        if (ring_we) begin
            r_ring[r_pos] <= r_in_dur;
        end
        if (ring_we && n_pos == r_pos) begin
            r_rd_data <= r_in_dur;
        end else begin
            r_rd_data <= r_ring[n_pos];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_vld       <= '0;
            r_rd_ok          <= 1'b0;
            r_pos            <= '0;
            r_window_over    <= '0;
            r_clean_run      <= '0;
            r_auto_bypass    <= 1'b0;
            r_calls          <= '0;
            r_overs          <= '0;
            r_bypasses       <= '0;
            r_faults         <= '0;
            r_trips          <= '0;
            r_latest         <= '0;
            r_largest        <= '0;
            r_route          <= ovwb_pkg::ROUTE_PROCESSED;
            r_bypass_engaged <= 1'b0;
        end else begin
            // Flash clear on recovery: drop every entry at once
            if (ring_clr) begin
                r_ring_vld <= '0;
                r_rd_ok    <= 1'b0;
            end else begin
                if (ring_we) begin
                    r_ring_vld[r_pos] <= 1'b1;
                end
                r_rd_ok <= (ring_we && n_pos == r_pos) || r_ring_vld[n_pos];
            end
            r_pos         <= n_pos;
            r_window_over <= n_window_over;
            r_clean_run   <= n_clean_run;
            r_auto_bypass <= n_auto_bypass;
            r_calls       <= n_calls;
            r_overs       <= n_overs;
            r_bypasses    <= n_bypasses;
            r_faults      <= n_faults;
            r_trips       <= n_trips;
            r_latest      <= n_latest;
            r_largest     <= n_largest;
            r_route       <= n_route;
            if (fire) begin
                r_bypass_engaged <= n_auto_bypass || r_manual_bypass;
            end
        end
    end

    // State advances only when the result slot frees, so it doubles as the result
    assign o_out_valid        = r_out_vld;
    assign o_route            = r_route;
    assign o_bypass_engaged   = r_bypass_engaged;
    assign o_call_count       = r_calls;
    assign o_over_count_total = r_overs;
    assign o_bypassed_total   = r_bypasses;
    assign o_fault_total      = r_faults;
    assign o_trip_total       = r_trips;
    assign o_last_duration    = r_latest;
    assign o_peak_duration    = r_largest;

endmodule

`default_nettype wire

[src/ovwb_checker.sv]
// ----------------------------------------------------------------------------
// Overrun window bypass monitor checker
// Port-level properties of the monitor, attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module ovwb_checker (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        o_in_ready,
    input  wire logic                        o_out_valid,
    input  wire logic                        i_out_ready,
    input  wire logic [ovwb_pkg::ROUTE_W-1:0] o_route,
    input  wire logic [ovwb_pkg::DATA_W-1:0] o_call_count,
    input  wire logic [ovwb_pkg::DATA_W-1:0] o_last_duration,
    input  wire logic [ovwb_pkg::DATA_W-1:0] o_peak_duration
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_route) && $stable(o_call_count))
        else $error("stalled result changed");

    // With no result pending, a new request is always taken
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("request blocked with empty result slot");

    a_peak_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last_duration <= o_peak_duration)
        else $error("last duration above peak");

endmodule

bind overrun_window_bypass_monitor ovwb_checker u_ovwb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_route         (o_route),
    .o_call_count    (o_call_count),
    .o_last_duration (o_last_duration),
    .o_peak_duration (o_peak_duration)
);

`default_nettype wire
